>>> design/rbb_pkg.sv
// Shared types and constants of the running box blur line block.
package rbb_pkg;

	localparam int PIX_W  = 8;
	localparam int NCH    = 4;
	localparam int SUM_W  = 15;
	localparam int DIV_W  = 7;
	localparam int QUO_W  = 8;
	localparam int POS_W  = 16;
	localparam int RAD_W  = 6;
	localparam int STEP_W = 7;
	localparam int CNT_W  = 3;

	localparam logic [RAD_W-1:0] RADIUS_RESET = 6'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WALK,
		ST_FLUSH,
		ST_DIVGO,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic start;
		logic issue;
		logic div_start;
		logic x_next;
		logic line_next;
	} cmd_t;

	typedef struct packed {
		logic has_out;
		logic walk_last;
		logic div_done;
		logic tail_done;
	} dp_flags_t;

endpackage

>>> design/rbb_div.sv
// Four-channel restoring divider, one quotient bit per cycle.
module rbb_div (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  start,
	input  logic [rbb_pkg::NCH-1:0][rbb_pkg::SUM_W-1:0]          dividend,
	input  logic [rbb_pkg::DIV_W-1:0]                             divisor,
	output logic [rbb_pkg::NCH-1:0][rbb_pkg::QUO_W-1:0]          quo,
	output logic                                                  done
);

	logic [rbb_pkg::NCH-1:0][rbb_pkg::SUM_W-1:0] rem_q;
	logic [rbb_pkg::NCH-1:0][rbb_pkg::QUO_W-1:0] quo_q;
	logic [rbb_pkg::SUM_W-1:0]                   dsh_q;
	logic [rbb_pkg::CNT_W-1:0]                   cnt_q;
	logic                                        busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '1;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Quotient fits in eight bits since each sum is at most 255 times the divisor.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			quo_q <= '0;
			dsh_q <= rbb_pkg::SUM_W'({divisor, {(rbb_pkg::QUO_W-1){1'b0}}});
		end else if (busy_q) begin
			for (int i = 0; i < rbb_pkg::NCH; i++) begin
				if (rem_q[i] >= dsh_q) begin
					rem_q[i] <= rem_q[i] - dsh_q;
					quo_q[i] <= {quo_q[i][rbb_pkg::QUO_W-2:0], 1'b1};
				end else begin
					quo_q[i] <= {quo_q[i][rbb_pkg::QUO_W-2:0], 1'b0};
				end
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign quo  = quo_q;
	assign done = busy_q && (cnt_q == '0);

endmodule

>>> design/rbb_ctrl.sv
// Sequencer of the box blur: accept, window walk, divide, result transfer.
module rbb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  rbb_pkg::dp_flags_t status,
	output rbb_pkg::cmd_t     cmd
);

	rbb_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			rbb_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (status.has_out) begin
						state_d = rbb_pkg::ST_START;
					end
				end
			end
			rbb_pkg::ST_START: begin
				cmd.start = 1'b1;
				state_d   = rbb_pkg::ST_WALK;
			end
			rbb_pkg::ST_WALK: begin
				cmd.issue = 1'b1;
				if (status.walk_last) begin
					state_d = rbb_pkg::ST_FLUSH;
				end
			end
			// let the final read land in the sums
			rbb_pkg::ST_FLUSH: begin
				state_d = rbb_pkg::ST_DIVGO;
			end
			rbb_pkg::ST_DIVGO: begin
				cmd.div_start = 1'b1;
				state_d       = rbb_pkg::ST_DIV;
			end
			rbb_pkg::ST_DIV: begin
				if (status.div_done) begin
					state_d = rbb_pkg::ST_OUT;
				end
			end
			rbb_pkg::ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					if (status.tail_done) begin
						cmd.line_next = 1'b1;
						state_d       = rbb_pkg::ST_IDLE;
					end else begin
						cmd.x_next = 1'b1;
						state_d    = rbb_pkg::ST_START;
					end
				end
			end
			default: begin
				state_d = rbb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> design/rbb_datapath.sv
// Datapath: pixel window store, position tracking, window sums and divider.
module rbb_datapath #(
	parameter int MAX_RADIUS     = 32,
	parameter int MAX_LINE_WIDTH = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           radius_we,
	input  logic [rbb_pkg::RAD_W-1:0]      radius_wdata,
	input  logic [rbb_pkg::NCH*rbb_pkg::PIX_W-1:0] px_data,
	input  logic                           px_sel,
	input  logic                           px_last,
	input  rbb_pkg::cmd_t                  cmd,
	output rbb_pkg::dp_flags_t             status,
	output logic [rbb_pkg::NCH*rbb_pkg::PIX_W-1:0] res_data,
	output logic                           res_sel,
	output logic                           res_end
);

	localparam int DEPTH = 2 * MAX_RADIUS + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int QW    = rbb_pkg::POS_W + 2;
	localparam int EW    = rbb_pkg::NCH * rbb_pkg::PIX_W + 1;
	localparam logic [rbb_pkg::RAD_W-1:0] MAX_R    = rbb_pkg::RAD_W'(MAX_RADIUS);
	localparam logic [rbb_pkg::POS_W-1:0] LAST_POS = rbb_pkg::POS_W'(MAX_LINE_WIDTH - 1);
	localparam logic [AW-1:0]             TOP_ADDR = AW'(DEPTH - 1);
	localparam logic [AW:0]               DEPTH_X  = (AW+1)'(DEPTH);

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_q;

	logic [rbb_pkg::RAD_W-1:0] radius_q;
	logic [rbb_pkg::RAD_W-1:0] r_eff;
	logic [rbb_pkg::POS_W-1:0] r16;
	logic [rbb_pkg::POS_W-1:0] p_q, x_q, xend_q;
	logic [AW-1:0]             wp_q, wp_inc, qaddr_q, rd_addr, start_addr;
	logic [AW:0]               back_k, start_tmp;
	logic [rbb_pkg::POS_W-1:0] back_cnt;
	logic signed [QW-1:0]      qpos_q;
	logic [rbb_pkg::STEP_W-1:0] step_q;
	logic                      last_q;
	logic                      last_now, p_ge_r;
	logic                      rd_v_s1, tap_s1;
	logic                      sel_q;
	logic [rbb_pkg::NCH-1:0][rbb_pkg::SUM_W-1:0] sum_q;
	logic [rbb_pkg::NCH-1:0][rbb_pkg::QUO_W-1:0] quo;
	logic                      div_done;

	// Clamp the radius register into 1..MAX_RADIUS.
	always_comb begin
		if (radius_q == '0) begin
			r_eff = rbb_pkg::RAD_W'(1);
		end else if (radius_q > MAX_R) begin
			r_eff = MAX_R;
		end else begin
			r_eff = radius_q;
		end
	end

	assign r16      = rbb_pkg::POS_W'(r_eff);
	assign last_now = px_last || (p_q >= LAST_POS);
	assign p_ge_r   = p_q >= r16;
	assign wp_inc   = (wp_q == TOP_ADDR) ? '0 : wp_q + 1'b1;

	// Store slot of position x - r, counted back from the newest slot.
	assign back_cnt   = p_q - x_q;
	assign back_k     = (AW+1)'(back_cnt) + (AW+1)'(r_eff);
	assign start_tmp  = {1'b0, wp_q} - back_k;
	assign start_addr = start_tmp[AW] ? AW'(start_tmp + DEPTH_X) : start_tmp[AW-1:0];

	// Clamp reads to the line: before the start reads slot 0, past the newest reads it.
	always_comb begin
		if (qpos_q[QW-1]) begin
			rd_addr = '0;
		end else if (qpos_q[QW-2:0] > {1'b0, p_q}) begin
			rd_addr = wp_q;
		end else begin
			rd_addr = qaddr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mem[wp_q] <= {px_sel, px_data};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= rbb_pkg::RADIUS_RESET;
			p_q      <= '0;
			wp_q     <= '0;
			x_q      <= '0;
			xend_q   <= '0;
			last_q   <= 1'b0;
			qpos_q   <= '0;
			qaddr_q  <= '0;
			step_q   <= '0;
			rd_v_s1  <= 1'b0;
			tap_s1   <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.issue;
			tap_s1  <= cmd.issue && (step_q == rbb_pkg::STEP_W'(r_eff));
			if (radius_we) begin
				// drop the line in progress
				radius_q <= radius_wdata;
				p_q      <= '0;
				wp_q     <= '0;
			end else if (cmd.accept) begin
				last_q <= last_now;
				if (last_now || p_ge_r) begin
					x_q    <= p_ge_r ? p_q - r16 : '0;
					xend_q <= last_now ? p_q : p_q - r16;
				end else begin
					p_q  <= p_q + 1'b1;
					wp_q <= wp_inc;
				end
			end else if (cmd.line_next) begin
				if (last_q) begin
					p_q  <= '0;
					wp_q <= '0;
				end else begin
					p_q  <= p_q + 1'b1;
					wp_q <= wp_inc;
				end
			end
			if (cmd.x_next) begin
				x_q <= x_q + 1'b1;
			end
			if (cmd.start) begin
				qpos_q  <= $signed({2'b00, x_q}) - $signed(QW'(r_eff));
				qaddr_q <= start_addr;
				step_q  <= '0;
			end else if (cmd.issue) begin
				qpos_q  <= qpos_q + $signed(QW'(1));
				qaddr_q <= (qaddr_q == TOP_ADDR) ? '0 : qaddr_q + 1'b1;
				step_q  <= step_q + 1'b1;
			end
		end
	end

	// Window sums: colors count only where alpha is nonzero.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sum_q <= '0;
		end else if (rd_v_s1) begin
			for (int c = 0; c < rbb_pkg::NCH - 1; c++) begin
				if (rd_q[(rbb_pkg::NCH-1)*rbb_pkg::PIX_W +: rbb_pkg::PIX_W] != '0) begin
					sum_q[c] <= sum_q[c]
						+ rbb_pkg::SUM_W'(rd_q[c*rbb_pkg::PIX_W +: rbb_pkg::PIX_W]);
				end
			end
			sum_q[rbb_pkg::NCH-1] <= sum_q[rbb_pkg::NCH-1]
				+ rbb_pkg::SUM_W'(rd_q[(rbb_pkg::NCH-1)*rbb_pkg::PIX_W +: rbb_pkg::PIX_W]);
		end
		if (tap_s1) begin
			sel_q <= rd_q[EW-1];
		end
	end

	rbb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  ({1'b0, r_eff} << 1 | rbb_pkg::DIV_W'(1)),
		.quo      (quo),
		.done     (div_done)
	);

	assign status.has_out   = last_now || p_ge_r;
	assign status.walk_last = step_q == {r_eff, 1'b0};
	assign status.div_done  = div_done;
	assign status.tail_done = x_q == xend_q;

	assign res_data = quo;
	assign res_sel  = sel_q;
	assign res_end  = last_q && (x_q == xend_q);

endmodule

>>> design/running_box_blur_line.sv
// Each result comes from a walk that reads the 2r+1 window slots, one read per cycle,
// and then the bit-serial divider; an item with no result is only stored in the window.
// One item is in work at a time; a last-of-line item releases up to r+1 results
// in turn, each walked and divided as above, before the next item is taken.
// Reset (arst_n low): radius goes to 5, line position to 0, controller to idle;
// the window store is not cleared.
module running_box_blur_line #(
	parameter int MAX_RADIUS     = 32,
	parameter int MAX_LINE_WIDTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        radius_we,
	input  logic [5:0]  radius_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // blue_in, green_in, red_in, alpha_in
	input  logic        s_tuser,   // in_selection
	input  logic        s_tlast,   // last_in_line
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // blue_out, green_out, red_out, alpha_out
	output logic        m_tuser,   // write_enable
	output logic        m_tlast    // line_end
);

	rbb_pkg::cmd_t      cmd;
	rbb_pkg::dp_flags_t status;

	rbb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	rbb_datapath #(
		.MAX_RADIUS     (MAX_RADIUS),
		.MAX_LINE_WIDTH (MAX_LINE_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.radius_we    (radius_we),
		.radius_wdata (radius_wdata),
		.px_data      (s_tdata),
		.px_sel       (s_tuser),
		.px_last      (s_tlast),
		.cmd          (cmd),
		.status       (status),
		.res_data     (m_tdata),
		.res_sel      (m_tuser),
		.res_end      (m_tlast)
	);

`ifndef ASSERT_OFF
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output sides active together");

	a_last_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("end-of-line transfer produced no result");

	a_line_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
		else $error("block not idle after line end transfer");
`endif

endmodule

>>> tb/sv/tb_top.sv
// Self-checking bench for running_box_blur_line: BGRA line stream in, box averages out.
`timescale 1ns / 1ps

module tb_top;

	localparam int BLUR_MAX_R  = 32;
	localparam int LINE_MAX    = 4096;
	localparam int WIN_DEPTH   = 2 * BLUR_MAX_R + 1;
	localparam int HOLD_CYCLES = 2 * BLUR_MAX_R + 13 + 24;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int LINE_PART   = 15;

	typedef struct packed {
		logic                      sel;
		logic [rbb_pkg::PIX_W-1:0] alpha;
		logic [rbb_pkg::PIX_W-1:0] red;
		logic [rbb_pkg::PIX_W-1:0] green;
		logic [rbb_pkg::PIX_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic   last;
		pixel_t px;
	} line_item_t;

	typedef struct packed {
		logic                      line_end;
		logic                      write_enable;
		logic [rbb_pkg::PIX_W-1:0] alpha;
		logic [rbb_pkg::PIX_W-1:0] red;
		logic [rbb_pkg::PIX_W-1:0] green;
		logic [rbb_pkg::PIX_W-1:0] blue;
	} blur_px_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      radius_we = 1'b0;
	logic [rbb_pkg::RAD_W-1:0] radius_wdata = '0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [31:0]               s_tdata = '0;   // blue_in, green_in, red_in, alpha_in
	logic                      s_tuser = 1'b0; // in_selection
	logic                      s_tlast = 1'b0; // last_in_line
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [31:0]               m_tdata;        // blue_out, green_out, red_out, alpha_out
	logic                      m_tuser;        // write_enable
	logic                      m_tlast;        // line_end

	// line model state
	pixel_t                    line_win [WIN_DEPTH];
	logic [rbb_pkg::RAD_W-1:0] radius_reg = rbb_pkg::RADIUS_RESET;
	int                        line_pos = 0;
	int                        eff_r;
	int                        cur_p;
	int                        out_x;

	line_item_t line_feed[$];
	blur_px_t   pending_avgs[$];
	line_item_t nxt;
	blur_px_t   want;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int err_cnt = 0;
	int cyc = 0;

	running_box_blur_line u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.radius_we    (radius_we),
		.radius_wdata (radius_wdata),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Average of positions x-r..x+r, clamped into 0..p; colour counts only where alpha is set.
	function automatic blur_px_t box_average(int x, int p, int r, bit at_end);
		int       sb, sg, sr, sa, q, div;
		pixel_t   px;
		blur_px_t res;
		sb = 0;
		sg = 0;
		sr = 0;
		sa = 0;
		div = 2 * r + 1;
		for (int d = -r; d <= r; d++) begin
			q = x + d;
			if (q < 0)
				q = 0;
			if (q > p)
				q = p;
			px = line_win[q % WIN_DEPTH];
			if (px.alpha != 0) begin
				sb += px.blue;
				sg += px.green;
				sr += px.red;
			end
			sa += px.alpha;
		end
		res.blue = rbb_pkg::PIX_W'(sb / div);
		res.green = rbb_pkg::PIX_W'(sg / div);
		res.red = rbb_pkg::PIX_W'(sr / div);
		res.alpha = rbb_pkg::PIX_W'(sa / div);
		res.write_enable = line_win[x % WIN_DEPTH].sel;
		res.line_end = at_end;
		return res;
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t px;
		px.blue = rbb_pkg::PIX_W'($urandom);
		px.green = rbb_pkg::PIX_W'($urandom);
		px.red = rbb_pkg::PIX_W'($urandom);
		px.alpha = rbb_pkg::PIX_W'($urandom);
		px.sel = 1'($urandom_range(1));
		case ($urandom_range(7))
			0: px.alpha = '0;
			1: px.alpha = '1;
			2: begin
				px.blue = '1;
				px.green = '1;
				px.red = '1;
			end
			3: begin
				px.blue = '0;
				px.green = '0;
				px.red = '0;
			end
			default: ;
		endcase
		return px;
	endfunction

	task automatic queue_line(int len, bit terminate);
		for (int i = 0; i < len; i++)
			line_feed.push_back({terminate && (i == len - 1), rand_pixel()});
	endtask

	// Hold until every transfer is out and every average has come back, then let the block drain.
	task automatic settle();
		do
			@(negedge clk);
		while (line_feed.size() != 0 || s_tvalid || pending_avgs.size() != 0);
		repeat (HOLD_CYCLES) @(posedge clk);
	endtask

	task automatic write_radius(logic [rbb_pkg::RAD_W-1:0] val);
		@(posedge clk);
		radius_we <= 1'b1;
		radius_wdata <= val;
		@(posedge clk);
		radius_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic compare_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			err_cnt++;
		end
	endtask

	// Driver and line predictor: predict at the accepting edge, then load the next transfer.
	always @(posedge clk) begin
		if (!arst_n) begin
			radius_reg = rbb_pkg::RADIUS_RESET;
			line_pos = 0;
			s_tvalid <= 1'b0;
		end else begin
			if (radius_we) begin
				radius_reg = radius_wdata;
				line_pos = 0;
			end
			if (s_tvalid && s_tready) begin
				eff_r = (radius_reg == 0) ? 1 :
					(radius_reg > BLUR_MAX_R) ? BLUR_MAX_R : int'(radius_reg);
				cur_p = line_pos;
				line_win[cur_p % WIN_DEPTH] = {s_tuser, s_tdata};
				if (s_tlast || cur_p >= LINE_MAX - 1) begin
					for (out_x = (cur_p >= eff_r) ? cur_p - eff_r : 0; out_x <= cur_p; out_x++)
						pending_avgs.push_back(box_average(out_x, cur_p, eff_r, out_x == cur_p));
					line_pos = 0;
				end else begin
					if (cur_p >= eff_r)
						pending_avgs.push_back(box_average(cur_p - eff_r, cur_p, eff_r, 1'b0));
					line_pos = cur_p + 1;
				end
			end
			if (!s_tvalid || s_tready) begin
				if (line_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = line_feed.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= nxt.px[31:0];
					s_tuser <= nxt.px.sel;
					s_tlast <= nxt.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each output transfer against the oldest predicted average.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_avgs.size() == 0) begin
					$display("%0t: unexpected output, expected none, actual %h",
						$time, {m_tlast, m_tuser, m_tdata});
					err_cnt++;
				end else begin
					want = pending_avgs.pop_front();
					compare_field("blue_out", want.blue, m_tdata[7:0]);
					compare_field("green_out", want.green, m_tdata[15:8]);
					compare_field("red_out", want.red, m_tdata[23:16]);
					compare_field("alpha_out", want.alpha, m_tdata[31:24]);
					compare_field("write_enable", want.write_enable, m_tuser);
					compare_field("line_end", want.line_end, m_tlast);
				end
			end
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc >= CYCLE_LIMIT) begin
			$display("[running_box_blur_line] ERROR");
			$finish;
		end
	end

	initial begin
		int n;
		int len;
		bit term;
		logic [rbb_pkg::RAD_W-1:0] rad;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset radius: single-pixel line, line shorter than the window, then a longer line
		line_feed.push_back({1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
		line_feed.push_back({1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00});
		line_feed.push_back({1'b0, 1'b1, 8'h00, 8'hFF, 8'hFF, 8'hFF});
		line_feed.push_back({1'b1, 1'b1, 8'h01, 8'hFF, 8'hFF, 8'hFF});
		for (int i = 0; i < 7; i++)
			line_feed.push_back(i[0] ? {i == 6, 1'b0, 32'h0000_0000} :
				{i == 6, 1'b1, 32'hFFFF_FFFF});
		settle();
		// zero acts as the smallest radius; end the phase mid-line
		write_radius('0);
		queue_line(4, 1'b1);
		queue_line(3, 1'b0);
		settle();
		// all ones acts as the largest radius and drops the open line
		write_radius('1);
		queue_line(3, 1'b1);
		settle();
		// a line longer than the store wraps the slot index
		write_radius(rbb_pkg::RAD_W'(BLUR_MAX_R));
		queue_line(70, 1'b1);

		for (int m = 0; m < 4; m++) begin
			for (int s = 0; s < 2; s++) begin
				settle();
				case ($urandom_range(3))
					0: rad = rbb_pkg::RAD_W'(1);
					1: rad = rbb_pkg::RAD_W'(BLUR_MAX_R);
					default: rad = rbb_pkg::RAD_W'($urandom_range(0, (1 << rbb_pkg::RAD_W) - 1));
				endcase
				write_radius(rad);
				send_idle_pct = (m == 1) ? 75 : (m == 3) ? 36 : 0;
				stall_pct = (m == 2) ? 75 : (m == 3) ? 36 : 0;
				n = 0;
				while (n < LINE_PART) begin
					case ($urandom_range(19)) inside
						[0:13]: len = $urandom_range(1, 12);
						[14:18]: len = $urandom_range(13, 40);
						default: len = $urandom_range(41, 90);
					endcase
					if (len > LINE_PART - n)
						len = LINE_PART - n;
					// the closing line is sometimes left open so that the write cuts it
					term = (n + len >= LINE_PART) ? ($urandom_range(3) != 0) : 1'b1;
					queue_line(len, term);
					n += len;
				end
			end
		end

		settle();

		if (err_cnt == 0)
			$display("[running_box_blur_line] OK");
		else
			$display("[running_box_blur_line] ERROR");
		$finish;
	end

endmodule
